@@ rtl/csa_pkg.sv @@
// Shared types and constants for the contiguous segment allocator.
// No dependencies; used by csa_table, csa_engine and the top level.
`default_nettype none
package csa_pkg;
    localparam int MAX_SEGMENTS = 32;
    localparam int ADDR_BITS    = 24;
    localparam int TB           = $clog2(MAX_SEGMENTS);
    localparam int CB           = $clog2(MAX_SEGMENTS + 1);
    localparam logic [ADDR_BITS-1:0] TOTAL_RESET = ADDR_BITS'(1048576);

    localparam logic [2:0] OP_FIRST   = 3'd0;
    localparam logic [2:0] OP_BEST    = 3'd1;
    localparam logic [2:0] OP_WORST   = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_COMPACT = 3'd4;
    localparam logic [2:0] OP_DUMP    = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOMEM   = 3'd1;
    localparam logic [2:0] ST_NOOWNER = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;

    typedef struct packed {
        logic [7:0]           owner;
        logic [ADDR_BITS-1:0] size;
    } seg_t;

    typedef struct packed {
        logic          en;
        logic [TB-1:0] addr;
        seg_t          data;
    } tbl_wr_t;
endpackage
`default_nettype wire

@@ rtl/csa_table.sv @@
// Segment table storage: one write port, one read port with registered data.
// Depends on csa_pkg.
`default_nettype none
module csa_table (
    input  wire logic                clk,
    input  wire csa_pkg::tbl_wr_t    wr,
    input  wire logic [csa_pkg::TB-1:0] rd_addr,
    output csa_pkg::seg_t            rd_data
);
    csa_pkg::seg_t mem [csa_pkg::MAX_SEGMENTS];
    csa_pkg::seg_t rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

@@ rtl/csa_engine.sv @@
// Sequencer for the segment table: scans, shifts, merges and packs entries
// one per step; a shared adder keeps the running base. Depends on csa_pkg and csa_table.
`default_nettype none
module csa_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_init,
    input  wire logic [csa_pkg::ADDR_BITS-1:0] total_size,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    opcode,
    input  wire logic [7:0]                    owner_id,
    input  wire logic [csa_pkg::ADDR_BITS-1:0] request_size,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic [csa_pkg::ADDR_BITS-1:0]      base_address,
    output logic [csa_pkg::ADDR_BITS-1:0]      segment_size,
    output logic [7:0]                         segment_owner,
    output logic                               last
);
    localparam int TB = csa_pkg::TB;
    localparam int CB = csa_pkg::CB;
    localparam int AB = csa_pkg::ADDR_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_EMIT,
        S_A_RD, S_A_EV, S_A_DEC, S_A_SH_RD, S_A_SH_WR, S_A_SPLIT, S_A_FIN,
        S_R_RD, S_R_EV, S_M_RD, S_M_EV, S_M_FIN,
        S_C_RD, S_C_EV, S_C_FIN,
        S_D_RD, S_D_EV
    } state_t;

    state_t            state_reg, state_next;
    logic              init_pend_reg, init_pend_next;
    logic [2:0]        op_reg, op_next;
    logic [7:0]        id_reg, id_next;
    logic [AB-1:0]     req_reg, req_next;
    logic [TB-1:0]     idx_reg, idx_next;
    logic [CB-1:0]     count_reg, count_next;
    logic [CB-1:0]     n_reg, n_next;
    logic [AB-1:0]     base_reg, base_next;
    logic [AB-1:0]     acc_reg, acc_next;
    logic              found_reg, found_next;
    logic [TB-1:0]     pick_reg, pick_next;
    logic [AB-1:0]     pick_size_reg, pick_size_next;
    logic [AB-1:0]     pick_base_reg, pick_base_next;
    logic [7:0]        pend_own_reg, pend_own_next;
    logic [TB-1:0]     widx_reg, widx_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [AB-1:0]     res_base_reg, res_base_next;
    logic [AB-1:0]     res_size_reg, res_size_next;
    logic [7:0]        res_owner_reg, res_owner_next;
    logic              res_last_reg, res_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        status_reg, status_next;
    logic [AB-1:0]     base_out_reg, base_out_next;
    logic [AB-1:0]     size_out_reg, size_out_next;
    logic [7:0]        owner_out_reg, owner_out_next;
    logic              last_reg, last_next;

    csa_pkg::tbl_wr_t  wr;
    logic [TB-1:0]     rd_addr;
    csa_pkg::seg_t     rd_data;
    logic              at_end;
    logic              out_free;
    logic              fit;
    logic [7:0]        eown;
    logic [AB-1:0]     sum;

    csa_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign at_end   = (({1'b0, idx_reg} + CB'(1)) == count_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign fit      = (rd_data.owner == 8'd0) && (rd_data.size >= req_reg);
    assign eown     = (idx_reg == pick_reg) ? 8'd0 : rd_data.owner;
    // shared adder: running base for scans and dumps
    assign sum      = base_reg + rd_data.size;

    always_comb
    begin
        state_next      = state_reg;
        init_pend_next  = init_pend_reg || cfg_init;
        op_next         = op_reg;
        id_next         = id_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        base_next       = base_reg;
        acc_next        = acc_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pick_size_next  = pick_size_reg;
        pick_base_next  = pick_base_reg;
        pend_own_next   = pend_own_reg;
        widx_next       = widx_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;
        res_size_next   = res_size_reg;
        res_owner_next  = res_owner_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        base_out_next   = base_out_reg;
        size_out_next   = size_out_reg;
        owner_out_next  = owner_out_reg;
        last_next       = last_reg;
        wr              = '0;
        rd_addr         = idx_reg;
        in_stall        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                in_stall        = init_pend_reg || cfg_init;
                res_status_next = csa_pkg::ST_OK;
                res_base_next   = '0;
                res_size_next   = '0;
                res_owner_next  = '0;
                res_last_next   = 1'b1;
                idx_next        = '0;
                n_next          = '0;
                base_next       = '0;
                acc_next        = '0;
                found_next      = 1'b0;
                if (init_pend_reg)
                begin
                    // reinitialise to one free segment
                    wr.en          = 1'b1;
                    wr.addr        = '0;
                    wr.data.owner  = '0;
                    wr.data.size   = total_size;
                    count_next     = CB'(1);
                    init_pend_next = cfg_init;
                end
                else if (in_valid && !cfg_init)
                begin
                    op_next  = opcode;
                    id_next  = owner_id;
                    req_next = request_size;
                    case (opcode)
                        csa_pkg::OP_FIRST, csa_pkg::OP_BEST, csa_pkg::OP_WORST:
                        begin
                            if (request_size == '0)
                            begin
                                res_status_next = csa_pkg::ST_ZERO;
                                state_next      = S_EMIT;
                            end
                            else if (owner_id == 8'd0)
                            begin
                                res_status_next = csa_pkg::ST_NOOWNER;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_A_RD;
                            end
                        end
                        csa_pkg::OP_RELEASE: state_next = S_R_RD;
                        csa_pkg::OP_COMPACT: state_next = S_C_RD;
                        csa_pkg::OP_DUMP:    state_next = S_D_RD;
                        default:             state_next = S_EMIT;
                    endcase
                end
            end

            // hand a result to the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    base_out_next  = res_base_reg;
                    size_out_next  = res_size_reg;
                    owner_out_next = res_owner_reg;
                    last_next      = res_last_reg;
                    if (res_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + TB'(1);
                        state_next = S_D_RD;
                    end
                end
            end

            // allocation: scan for a fitting free segment
            S_A_RD: state_next = S_A_EV;
            S_A_EV:
            begin
                base_next = sum;
                if (fit && (!found_reg
                    || (op_reg == csa_pkg::OP_BEST && rd_data.size < pick_size_reg)
                    || (op_reg == csa_pkg::OP_WORST && rd_data.size > pick_size_reg)))
                begin
                    found_next     = 1'b1;
                    pick_next      = idx_reg;
                    pick_size_next = rd_data.size;
                    pick_base_next = base_reg;
                end
                if (at_end || (fit && op_reg == csa_pkg::OP_FIRST))
                begin
                    state_next = S_A_DEC;
                end
                else
                begin
                    idx_next   = idx_reg + TB'(1);
                    state_next = S_A_RD;
                end
            end
            S_A_DEC:
            begin
                res_owner_next = id_reg;
                res_base_next  = pick_base_reg;
                res_size_next  = req_reg;
                if (!found_reg)
                begin
                    res_status_next = csa_pkg::ST_NOMEM;
                    res_owner_next  = '0;
                    res_base_next   = '0;
                    res_size_next   = '0;
                    state_next      = S_EMIT;
                end
                else if (pick_size_reg > req_reg)
                begin
                    if (count_reg == CB'(csa_pkg::MAX_SEGMENTS))
                    begin
                        res_status_next = csa_pkg::ST_FULL;
                        res_owner_next  = '0;
                        res_base_next   = '0;
                        res_size_next   = '0;
                        state_next      = S_EMIT;
                    end
                    else if (count_reg > ({1'b0, pick_reg} + CB'(1)))
                    begin
                        widx_next  = count_reg[TB-1:0];
                        state_next = S_A_SH_RD;
                    end
                    else
                    begin
                        state_next = S_A_SPLIT;
                    end
                end
                else
                begin
                    wr.en         = 1'b1;
                    wr.addr       = pick_reg;
                    wr.data.owner = id_reg;
                    wr.data.size  = req_reg;
                    state_next    = S_EMIT;
                end
            end
            // shift the tail up by one entry
            S_A_SH_RD:
            begin
                rd_addr    = widx_reg - TB'(1);
                state_next = S_A_SH_WR;
            end
            S_A_SH_WR:
            begin
                wr.en     = 1'b1;
                wr.addr   = widx_reg;
                wr.data   = rd_data;
                widx_next = widx_reg - TB'(1);
                if ((widx_reg - TB'(1)) == (pick_reg + TB'(1)))
                begin
                    state_next = S_A_SPLIT;
                end
                else
                begin
                    state_next = S_A_SH_RD;
                end
            end
            S_A_SPLIT:
            begin
                wr.en         = 1'b1;
                wr.addr       = pick_reg + TB'(1);
                wr.data.owner = '0;
                wr.data.size  = pick_size_reg - req_reg;
                state_next    = S_A_FIN;
            end
            S_A_FIN:
            begin
                wr.en         = 1'b1;
                wr.addr       = pick_reg;
                wr.data.owner = id_reg;
                wr.data.size  = req_reg;
                count_next    = count_reg + CB'(1);
                state_next    = S_EMIT;
            end

            // release: find the first segment of the owner
            S_R_RD: state_next = S_R_EV;
            S_R_EV:
            begin
                base_next = sum;
                if (id_reg != 8'd0 && rd_data.owner == id_reg)
                begin
                    pick_next      = idx_reg;
                    res_base_next  = base_reg;
                    res_size_next  = rd_data.size;
                    res_owner_next = id_reg;
                    idx_next       = '0;
                    state_next     = S_M_RD;
                end
                else if (at_end)
                begin
                    res_status_next = csa_pkg::ST_NOOWNER;
                    state_next      = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + TB'(1);
                    state_next = S_R_RD;
                end
            end
            // merge pass: fold neighbouring free entries into a pending one
            S_M_RD: state_next = S_M_EV;
            S_M_EV:
            begin
                if (idx_reg != '0 && pend_own_reg == 8'd0 && eown == 8'd0)
                begin
                    acc_next = acc_reg + rd_data.size;
                end
                else
                begin
                    if (idx_reg != '0)
                    begin
                        wr.en         = 1'b1;
                        wr.addr       = n_reg[TB-1:0];
                        wr.data.owner = pend_own_reg;
                        wr.data.size  = acc_reg;
                        n_next        = n_reg + CB'(1);
                    end
                    pend_own_next = eown;
                    acc_next      = rd_data.size;
                end
                if (at_end)
                begin
                    state_next = S_M_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + TB'(1);
                    state_next = S_M_RD;
                end
            end
            S_M_FIN:
            begin
                wr.en         = 1'b1;
                wr.addr       = n_reg[TB-1:0];
                wr.data.owner = pend_own_reg;
                wr.data.size  = acc_reg;
                count_next    = n_reg + CB'(1);
                state_next    = S_EMIT;
            end

            // compact: pack owned entries, sum free space
            S_C_RD: state_next = S_C_EV;
            S_C_EV:
            begin
                if (rd_data.owner == 8'd0)
                begin
                    acc_next = acc_reg + rd_data.size;
                end
                else
                begin
                    wr.en     = 1'b1;
                    wr.addr   = n_reg[TB-1:0];
                    wr.data   = rd_data;
                    n_next    = n_reg + CB'(1);
                    base_next = sum;
                end
                if (at_end)
                begin
                    state_next = S_C_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + TB'(1);
                    state_next = S_C_RD;
                end
            end
            S_C_FIN:
            begin
                res_base_next = base_reg;
                res_size_next = acc_reg;
                count_next    = n_reg;
                if (acc_reg != '0 || n_reg == '0)
                begin
                    wr.en         = 1'b1;
                    wr.addr       = n_reg[TB-1:0];
                    wr.data.owner = '0;
                    wr.data.size  = acc_reg;
                    count_next    = n_reg + CB'(1);
                end
                state_next = S_EMIT;
            end

            // status dump: one item per entry
            S_D_RD: state_next = S_D_EV;
            S_D_EV:
            begin
                res_status_next = csa_pkg::ST_OK;
                res_base_next   = base_reg;
                res_size_next   = rd_data.size;
                res_owner_next  = rd_data.owner;
                res_last_next   = at_end;
                base_next       = sum;
                state_next      = S_EMIT;
            end

            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_pend_reg <= 1'b1;
            count_reg     <= CB'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_pend_reg <= init_pend_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        base_reg       <= base_next;
        acc_reg        <= acc_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        pick_size_reg  <= pick_size_next;
        pick_base_reg  <= pick_base_next;
        pend_own_reg   <= pend_own_next;
        widx_reg       <= widx_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
        res_size_reg   <= res_size_next;
        res_owner_reg  <= res_owner_next;
        res_last_reg   <= res_last_next;
        status_reg     <= status_next;
        base_out_reg   <= base_out_next;
        size_out_reg   <= size_out_next;
        owner_out_reg  <= owner_out_next;
        last_reg       <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign base_address  = base_out_reg;
    assign segment_size  = size_out_reg;
    assign segment_owner = owner_out_reg;
    assign last          = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        !init_pend_reg |-> (count_reg != '0 && count_reg <= CB'(csa_pkg::MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> ({1'b0, wr.addr} <= count_reg))
        else $error("table write beyond the live entries");

    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !last_reg) |-> (state_reg != S_IDLE))
        else $error("idle while a dump is unfinished");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("item accepted while busy");
endmodule
`default_nettype wire

@@ rtl/contiguous_segment_allocator_unit.sv @@
// Contiguous segment allocator: APB register file and item channels.
// Depends on csa_pkg and csa_engine.
//
// Usage: an item (opcode, owner_id, request_size) is taken when in_valid is
// high and in_stall low. Allocation (first, best, worst fit), release and
// compact give one result item; a status dump gives one item per segment,
// last marks the final one. Results leave through an output register on
// out_valid/out_stall, and the next item may be taken while a result waits.
// Each item is worked by one sequencer over the segment table memory, one
// entry at a time (read, then evaluate; scans keep the running base in a
// shared adder). While out_stall holds, the engine waits at its next
// result. Reset sets total_size to 1048576 and the table is set to one free
// segment in the cycle after reset; writing total_size does the same once
// the engine is idle. Items are not taken from that write until the table
// is set.
`default_nettype none
module contiguous_segment_allocator_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    opcode,
    input  wire logic [7:0]                    owner_id,
    input  wire logic [csa_pkg::ADDR_BITS-1:0] request_size,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic [csa_pkg::ADDR_BITS-1:0]      base_address,
    output logic [csa_pkg::ADDR_BITS-1:0]      segment_size,
    output logic [7:0]                         segment_owner,
    output logic                               last
);
    logic [csa_pkg::ADDR_BITS-1:0] total_reg;
    logic                          cfg_wr;

    // decode a write to the size register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(total_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= csa_pkg::TOTAL_RESET;
        end
        else if (cfg_wr)
        begin
            total_reg <= pwdata[csa_pkg::ADDR_BITS-1:0];
        end
    end

    csa_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_init      (cfg_wr),
        .total_size    (total_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .owner_id      (owner_id),
        .request_size  (request_size),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .base_address  (base_address),
        .segment_size  (segment_size),
        .segment_owner (segment_owner),
        .last          (last)
    );
endmodule
`default_nettype wire
